>>> hdl/block_buffer_cache_lookup_lru_defines.svh
// Assertion macros used by the buffer cache tag table top module.
// Defining NO_ASSERTIONS leaves every macro body empty.
`ifndef BLOCK_BUFFER_CACHE_LOOKUP_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LOOKUP_LRU_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define BBCL_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error("bbcl: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define BBCL_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error("bbcl: next-cycle check failed");
`else
`define BBCL_ASSERT_NOW(label, ck, rs, ante, cons)
`define BBCL_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

>>> hdl/bbcl_pkg.sv
// Types and constants of the buffer cache tag table.
// No dependencies; used by the interfaces, the top module and bbcl_scan.
`default_nettype none

package bbcl_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  localparam logic [7:0]  COUNT_MAX   = 8'hFF;
  localparam logic [31:0] STAMP_NEVER = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  entry;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [4:0] result_entry;
    logic       hit;
    logic       needs_read;
    logic       no_free;
  } out_item_t;

  // One buffer tag record as it is held in the tag memory.
  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block;
    logic [7:0]  count;
    logic [31:0] stamp;
    logic        cvalid;
    logic        present;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

  typedef struct packed {
    logic        match_found;
    logic        best_found;
    logic [31:0] best_stamp;
    entry_t      match_rec;
  } scan_stat_t;

endpackage

`default_nettype wire

>>> hdl/bbcl_if.sv
// Valid/ready channel interfaces for the request and result transactions.
// Depends on bbcl_pkg for the payload types.
`default_nettype none

interface bbcl_in_if;
  import bbcl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbcl_out_if;
  import bbcl_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/block_buffer_cache_lookup_lru.sv
// Buffer cache tag table: lookup with reference counts, release-stamp LRU.
// Depends on bbcl_pkg, bbcl_if, bbcl_ram, bbcl_scan and the defines header.
//
// Usage: requests arrive on in_chan (valid/ready), one transaction at a time.
// A lookup carries device and block_number; release, pin and unpin carry
// entry, and release also carries now. Every request yields exactly one
// result transaction on out_chan, in request order.
// Operation: a lookup sweeps the tag memory through its single read port,
// one entry per cycle, then writes back the matching or chosen entry.
// Release, pin and unpin with an entry in range read and write back that
// one entry. A new request is accepted at the earliest in the cycle after
// the previous result is loaded into the output register, so the next
// request may enter while that result still waits.
// Reset: rst_n is synchronous and active low. All entries then read as zero
// through per-entry valid bits; no clearing pass is needed.
// Stall: the result stays in the output register while out_chan.ready is low;
// a following request is worked on but its result waits until the register
// frees up.
`default_nettype none
`include "block_buffer_cache_lookup_lru_defines.svh"

module block_buffer_cache_lookup_lru #(
  parameter int NUM_ENTRIES = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  bbcl_in_if.sink    in_chan,
  bbcl_out_if.source out_chan
);
  import bbcl_pkg::*;

  localparam int               IDX_W    = $clog2(NUM_ENTRIES);
  localparam int               REC_W    = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LK_WR,
    S_MOD,
    S_RESULT
  } state_t;

  state_t     state_r, state_nxt;
  in_item_t   req_r, req_nxt;
  out_item_t  res_r, res_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]       rd_addr_r;
  logic                   rd_vld_r;
  logic [NUM_ENTRIES-1:0] entry_valid_r;

  logic             in_acc;
  logic             in_range;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  entry_t           cur_rec;

  scan_ctrl_t       scan_ctrl;
  scan_stat_t       scan_stat;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] best_idx;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_range       = (32'(in_chan.data.entry) < NUM_ENTRIES);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Entries never written since reset read as all zero.
  assign cur_rec = rd_vld_r ? entry_t'(ram_rdata) : entry_t'('0);

  bbcl_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbcl_scan #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (scan_ctrl),
    .idx          (rd_addr_r),
    .rec          (cur_rec),
    .device       (req_r.device),
    .block_number (req_r.block_number),
    .stat         (scan_stat),
    .match_idx    (match_idx),
    .best_idx     (best_idx)
  );

  always_comb begin
    state_nxt        = state_r;
    req_nxt          = req_r;
    res_nxt          = res_r;
    out_data_nxt     = out_data_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    ram_re           = 1'b0;
    ram_raddr        = rd_addr_r;
    ram_we           = 1'b0;
    ram_waddr        = rd_addr_r;
    ram_wdata        = cur_rec;
    scan_ctrl.clear  = 1'b0;
    scan_ctrl.sample = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_chan.data;
          res_nxt = '0;
          if (in_chan.data.operation == OP_LOOKUP) begin
            ram_re          = 1'b1;
            ram_raddr       = '0;
            scan_ctrl.clear = 1'b1;
            state_nxt       = S_SCAN;
          end else if (in_range) begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(in_chan.data.entry);
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        scan_ctrl.sample = 1'b1;
        if (rd_addr_r == LAST_IDX) begin
          state_nxt = S_LK_WR;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(rd_addr_r + 1'b1);
        end
      end
      S_LK_WR: begin
        if (scan_stat.match_found) begin
          ram_we           = 1'b1;
          ram_waddr        = match_idx;
          ram_wdata        = scan_stat.match_rec;
          ram_wdata.cvalid = 1'b1;
          if (scan_stat.match_rec.count != COUNT_MAX) begin
            ram_wdata.count = scan_stat.match_rec.count + 8'd1;
          end
          res_nxt.result_entry = 5'(match_idx);
          res_nxt.hit          = 1'b1;
          res_nxt.needs_read   = !scan_stat.match_rec.cvalid;
        end else if (scan_stat.best_found) begin
          ram_we            = 1'b1;
          ram_waddr         = best_idx;
          ram_wdata.device  = req_r.device;
          ram_wdata.block   = req_r.block_number;
          ram_wdata.count   = 8'd1;
          ram_wdata.stamp   = scan_stat.best_stamp;
          ram_wdata.cvalid  = 1'b1;
          ram_wdata.present = 1'b1;
          res_nxt.result_entry = 5'(best_idx);
          res_nxt.needs_read   = 1'b1;
        end else begin
          res_nxt.no_free = 1'b1;
        end
        state_nxt = S_RESULT;
      end
      S_MOD: begin
        ram_we = 1'b1;
        unique case (req_r.operation)
          OP_RELEASE: begin
            if (cur_rec.count != 8'd0) begin
              ram_wdata.count = cur_rec.count - 8'd1;
              if (cur_rec.count == 8'd1) begin
                ram_wdata.stamp = req_r.now;
              end
            end
          end
          OP_PIN: begin
            if (cur_rec.count != COUNT_MAX) begin
              ram_wdata.count = cur_rec.count + 8'd1;
            end
          end
          OP_UNPIN: begin
            if (cur_rec.count != 8'd0) begin
              ram_wdata.count = cur_rec.count - 8'd1;
            end
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Read address and the entry's written flag travel with the RAM read.
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_addr_r <= ram_raddr;
      rd_vld_r  <= entry_valid_r[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (ram_we) begin
      entry_valid_r[ram_waddr] <= 1'b1;
    end
  end

  `BBCL_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_acc, state_r != S_IDLE)
  `BBCL_ASSERT_NOW(a_write_only_in_update, clk, rst_n, ram_we,
                   (state_r == S_LK_WR) || (state_r == S_MOD))
  `BBCL_ASSERT_NOW(a_no_free_exclusive, clk, rst_n, out_valid_r && out_data_r.no_free,
                   !out_data_r.hit && !out_data_r.needs_read)
  `BBCL_ASSERT_NEXT(a_result_loads_slot, clk, rst_n,
                    (state_r == S_RESULT) && (!out_valid_r || out_chan.ready),
                    out_valid_r && (state_r == S_IDLE))

endmodule

`default_nettype wire

>>> hdl/bbcl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bbcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bbcl_scan.sv
// Lookup sweep tracker: first tag match and oldest free entry over the scan.
// Depends on bbcl_pkg.
`default_nettype none

module bbcl_scan #(
  parameter int NUM_ENTRIES = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bbcl_pkg::scan_ctrl_t           ctrl,
  input  wire logic [$clog2(NUM_ENTRIES)-1:0] idx,
  input  wire bbcl_pkg::entry_t               rec,
  input  wire logic [7:0]                     device,
  input  wire logic [31:0]                    block_number,
  output      bbcl_pkg::scan_stat_t           stat,
  output      logic [$clog2(NUM_ENTRIES)-1:0] match_idx,
  output      logic [$clog2(NUM_ENTRIES)-1:0] best_idx
);
  import bbcl_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  logic             match_found_r;
  logic             best_found_r;
  logic [31:0]      best_stamp_r;
  entry_t           match_rec_r;
  logic [IDX_W-1:0] match_idx_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             is_match;
  logic             is_better;

  assign is_match  = !match_found_r && rec.present &&
                     (rec.device == device) && (rec.block == block_number);
  // Strict compare keeps the lowest index on equal stamps, and a stamp of
  // all ones can never beat the initial value.
  assign is_better = (rec.count == 8'd0) && (rec.stamp < best_stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      best_found_r  <= 1'b0;
      best_stamp_r  <= STAMP_NEVER;
    end else if (ctrl.clear) begin
      match_found_r <= 1'b0;
      best_found_r  <= 1'b0;
      best_stamp_r  <= STAMP_NEVER;
    end else if (ctrl.sample) begin
      if (is_match) begin
        match_found_r <= 1'b1;
      end
      if (is_better) begin
        best_found_r <= 1'b1;
        best_stamp_r <= rec.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample && is_match) begin
      match_rec_r <= rec;
      match_idx_r <= idx;
    end
    if (ctrl.sample && is_better) begin
      best_idx_r <= idx;
    end
  end

  assign stat      = scan_stat_t'({match_found_r, best_found_r, best_stamp_r, match_rec_r});
  assign match_idx = match_idx_r;
  assign best_idx  = best_idx_r;

endmodule

`default_nettype wire
